>>> src/stsp_pkg.sv
// ----------------------------------------------------------------------------
// stsp_pkg: shared types and constants of the shell token splitter
// Character codes, lexer modes, lexer state and result word layout.
// ----------------------------------------------------------------------------
package stsp_pkg;

   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_PIPE   = 8'h7C;
   localparam logic [7:0] CH_AMP    = 8'h26;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;

   localparam int RSP_DATA_W = 16;

   typedef enum logic [2:0] {
      MODE_NORMAL = 3'd0,
      MODE_SQUOTE = 3'd1,
      MODE_DQUOTE = 3'd2,
      MODE_PIPE   = 3'd3,
      MODE_AMP    = 3'd4
   } stsp_mode_type;

   typedef struct packed {
      logic          word_open;
      stsp_mode_type mode;
   } stsp_state_type;

   localparam stsp_state_type STATE_RESET = '{word_open: 1'b0, mode: MODE_NORMAL};

   typedef struct packed {
      logic       last_of_run;
      logic       stream_done;
      logic       quote_error;
      logic       token_done;
      logic [7:0] token_char;
      logic       char_valid;
   } stsp_result_type;

   typedef struct packed {
      logic [1:0]      count;
      stsp_result_type res1;
      stsp_result_type res0;
   } stsp_lex_out_type;

   function automatic stsp_result_type mk_result(logic valid, logic [7:0] ch, logic done,
                                                 logic qerr, logic sdone);
      stsp_result_type r;
      r.char_valid  = valid;
      r.token_char  = ch;
      r.token_done  = done;
      r.quote_error = qerr;
      r.stream_done = sdone;
      r.last_of_run = 1'b0;
      return r;
   endfunction

endpackage

>>> src/stsp_lexer.sv
// ----------------------------------------------------------------------------
// stsp_lexer: next-state and result decode for one input word
// Produces up to two results and the lexer state after the word.
// ----------------------------------------------------------------------------
module stsp_lexer (
   input  stsp_pkg::stsp_state_type   cur_state,
   input  logic [7:0]                 text_byte,
   input  logic                       end_of_text,
   output stsp_pkg::stsp_state_type   next_state,
   output stsp_pkg::stsp_lex_out_type lex_out
);
   import stsp_pkg::*;

   stsp_result_type slot [2];
   logic [1:0]      n;
   logic            w;
   logic            do_normal;
   logic            blank;
   logic [7:0]      quote_ch;
   logic [7:0]      op_ch;

   assign blank    = (text_byte == CH_SPACE) || (text_byte >= CH_TAB && text_byte <= CH_CR);
   assign quote_ch = (cur_state.mode == MODE_SQUOTE) ? CH_SQUOTE : CH_DQUOTE;
   assign op_ch    = (cur_state.mode == MODE_PIPE) ? CH_PIPE : CH_AMP;

   always_comb begin
      n          = 2'd0;
      slot[0]    = mk_result(1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
      slot[1]    = mk_result(1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
      next_state = cur_state;
      w          = cur_state.word_open;
      do_normal  = 1'b0;

      unique case (cur_state.mode)
         MODE_SQUOTE, MODE_DQUOTE: begin
            if (end_of_text) begin
               slot[0]    = mk_result(1'b0, 8'h00, 1'b0, 1'b1, 1'b1);
               n          = 2'd1;
               next_state = STATE_RESET;
            end else if (text_byte == quote_ch) begin
               next_state.mode = MODE_NORMAL;
            end else begin
               slot[0]              = mk_result(1'b1, text_byte, 1'b0, 1'b0, 1'b0);
               n                    = 2'd1;
               next_state.word_open = 1'b1;
            end
         end
         MODE_PIPE, MODE_AMP: begin
            if (end_of_text) begin
               slot[0]    = mk_result(1'b0, 8'h00, 1'b1, 1'b0, 1'b1);
               n          = 2'd1;
               next_state = STATE_RESET;
            end else if (text_byte == op_ch) begin
               slot[0]    = mk_result(1'b1, text_byte, 1'b1, 1'b0, 1'b0);
               n          = 2'd1;
               next_state = STATE_RESET;
            end else begin
               slot[0]    = mk_result(1'b0, 8'h00, 1'b1, 1'b0, 1'b0);
               n          = 2'd1;
               next_state = STATE_RESET;
               w          = 1'b0;
               do_normal  = 1'b1;
            end
         end
         default: begin
            next_state.mode = MODE_NORMAL;
            if (end_of_text) begin
               slot[0]    = mk_result(1'b0, 8'h00, w, 1'b0, 1'b1);
               n          = 2'd1;
               next_state = STATE_RESET;
            end else begin
               do_normal = 1'b1;
            end
         end
      endcase

      if (do_normal) begin
         priority if (blank) begin
            if (w) begin
               slot[n[0]] = mk_result(1'b0, 8'h00, 1'b1, 1'b0, 1'b0);
               n          = n + 2'd1;
            end
            next_state.word_open = 1'b0;
         end else if (text_byte == CH_SEMI) begin
            if (w) begin
               slot[n[0]] = mk_result(1'b0, 8'h00, 1'b1, 1'b0, 1'b0);
               n          = n + 2'd1;
            end
            slot[n[0]]           = mk_result(1'b1, text_byte, 1'b1, 1'b0, 1'b0);
            n                    = n + 2'd1;
            next_state.word_open = 1'b0;
         end else if (text_byte == CH_PIPE || text_byte == CH_AMP) begin
            if (w) begin
               slot[n[0]] = mk_result(1'b0, 8'h00, 1'b1, 1'b0, 1'b0);
               n          = n + 2'd1;
            end
            slot[n[0]]           = mk_result(1'b1, text_byte, 1'b0, 1'b0, 1'b0);
            n                    = n + 2'd1;
            next_state.word_open = 1'b1;
            next_state.mode      = (text_byte == CH_PIPE) ? MODE_PIPE : MODE_AMP;
         end else if (text_byte == CH_SQUOTE) begin
            next_state.mode = MODE_SQUOTE;
         end else if (text_byte == CH_DQUOTE) begin
            next_state.mode = MODE_DQUOTE;
         end else begin
            slot[n[0]]           = mk_result(1'b1, text_byte, 1'b0, 1'b0, 1'b0);
            n                    = n + 2'd1;
            next_state.word_open = 1'b1;
         end
      end

      if (n == 2'd1) begin
         slot[0].last_of_run = 1'b1;
      end
      if (n == 2'd2) begin
         slot[1].last_of_run = 1'b1;
      end

      lex_out.count = n;
      lex_out.res0  = slot[0];
      lex_out.res1  = slot[1];
   end

endmodule

>>> src/stsp_rsp_queue.sv
// ----------------------------------------------------------------------------
// stsp_rsp_queue: four-entry result queue
// Takes up to two results a cycle, hands out one; ready while two are free.
// ----------------------------------------------------------------------------
module stsp_rsp_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [1:0]                push_count,
   input  stsp_pkg::stsp_result_type push_res0,
   input  stsp_pkg::stsp_result_type push_res1,
   input  logic                      pop,
   output stsp_pkg::stsp_result_type head,
   output logic                      head_valid,
   output logic                      room
);
   import stsp_pkg::*;

   stsp_result_type entries_ff [4];
   logic [1:0]      wr_ptr_ff, wr_ptr_in;
   logic [1:0]      rd_ptr_ff, rd_ptr_in;
   logic [2:0]      count_ff, count_in;
   logic            do_pop;

   assign head_valid = (count_ff != 3'd0);
   assign head       = entries_ff[rd_ptr_ff];
   assign room       = (count_ff <= 3'd2);
   assign do_pop     = pop && head_valid;

   assign wr_ptr_in = wr_ptr_ff + push_count;
   assign rd_ptr_in = rd_ptr_ff + {1'b0, do_pop};
   assign count_in  = count_ff + {1'b0, push_count} - {2'b00, do_pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         entries_ff[wr_ptr_ff] <= push_res0;
      end
      if (push_count == 2'd2) begin
         entries_ff[wr_ptr_ff + 2'd1] <= push_res1;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 3'd4)
      else $error("result queue count out of range");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (wr_ptr_ff - rd_ptr_ff) == count_ff[1:0])
      else $error("result queue pointers disagree with count");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      (push_count != 2'd0) |-> room)
      else $error("result queue pushed without room");

endmodule

>>> src/shell_token_splitter_core.sv
// ----------------------------------------------------------------------------
// shell_token_splitter_core: streaming shell command tokenizer
// Splits a byte stream into token characters with token-end marks.
//
//  channel | dir | tdata                       | tlast
//  req     | in  | text_byte                   | end_of_text
//  rsp     | out | see rsp_tdata port comment  | last_of_run
//
// One input word per cycle while req_tready is high; its results are registered
// into the result queue when it is taken. A word that yields two results needs
// two output transfers, absorbed by the four-entry result queue.
// Input is taken while at least two queue entries are free, independent of
// rsp_tready. Reset is synchronous and returns the lexer to normal mode with
// no token open and empties the queue.
// ----------------------------------------------------------------------------
module shell_token_splitter_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [7:0]                     req_tdata,   // [7:0] text_byte
   input  logic                           req_tlast,   // end_of_text
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [stsp_pkg::RSP_DATA_W-1:0] rsp_tdata,  // [0] char_valid, [8:1] token_char,
                                                       // [9] token_done, [10] quote_error,
                                                       // [11] stream_done, [15:12] zero
   output logic                           rsp_tlast    // last_of_run
);
   import stsp_pkg::*;

   stsp_state_type   state_ff, state_in;
   stsp_state_type   lex_next;
   stsp_lex_out_type lex_out;
   stsp_result_type  head;
   logic             accept;
   logic             room;
   logic [1:0]       push_count;

   assign req_tready = room;
   assign accept     = req_tvalid && room;
   assign push_count = accept ? lex_out.count : 2'd0;
   assign state_in   = accept ? lex_next : state_ff;

   stsp_lexer u_lexer (
      .cur_state   (state_ff),
      .text_byte   (req_tdata),
      .end_of_text (req_tlast),
      .next_state  (lex_next),
      .lex_out     (lex_out)
   );

   stsp_rsp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_count (push_count),
      .push_res0  (lex_out.res0),
      .push_res1  (lex_out.res1),
      .pop        (rsp_tready),
      .head       (head),
      .head_valid (rsp_tvalid),
      .room       (room)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RESET;
      end else begin
         state_ff <= state_in;
      end
   end

   assign rsp_tdata = {4'b0000, head.stream_done, head.quote_error, head.token_done,
                       head.token_char, head.char_valid};
   assign rsp_tlast = head.last_of_run;

   a_eot_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tlast) |=> (state_ff == STATE_RESET))
      else $error("lexer state not cleared after end of text");

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && head.stream_done) |-> head.last_of_run)
      else $error("stream end not on last word of run");

   a_qerr_form: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && head.quote_error) |-> (head.stream_done && !head.token_done))
      else $error("malformed quote error word");

endmodule
